@@ rtl/rmfh_pkg.sv @@
package rmfh_pkg;

   localparam int THREADS_DEF    = 16;
   localparam int DEPTH_BITS_DEF = 16;
   localparam int TID_W          = 4;
   localparam int DEPTH_NOW_W    = 16;

   typedef enum logic {
      OP_LOCK   = 1'b0,
      OP_UNLOCK = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_GRANTED   = 3'd0,
      ST_NESTED    = 3'd1,
      ST_FAILED    = 3'd2,
      ST_QUEUED    = 3'd3,
      ST_NOT_OWNER = 3'd4,
      ST_HELD      = 3'd5,
      ST_FREED     = 3'd6,
      ST_FULL      = 3'd7
   } status_type;

   typedef struct packed {
      op_type             op;
      logic [TID_W-1:0]   thread_id;
      logic               wait_req;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic                     woken_valid;
      logic [TID_W-1:0]         woken_thread;
      logic [DEPTH_NOW_W-1:0]   depth_now;
   } rsp_type;

endpackage

@@ rtl/rmfh_ram.sv @@
module rmfh_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the old contents when both ports hit the same entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/recursive_mutex_fifo_handoff_core.sv @@
// Channel   Direction  Handshake                 Payload
// request   in         start, busy               req_data  (op, thread_id, wait_req)
// result    out        rsp_valid (one cycle)     rsp_data  (status, woken_thread, ...)
//
// Every request is accepted in the cycle it is presented; busy stays low.
// The registered result shows in the next cycle for exactly one cycle, one per request.
// State lives in flip-flops and the waiter queue RAM; the queue head is prefetched
// so that a handoff need not wait for a RAM read. The receiver cannot stall the block.
// Reset is synchronous and frees the mutex and empties the queue at once.
module recursive_mutex_fifo_handoff_core #(
   parameter int THREADS    = rmfh_pkg::THREADS_DEF,
   parameter int DEPTH_BITS = rmfh_pkg::DEPTH_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rmfh_pkg::req_type req_data,
   output logic              rsp_valid,
   output rmfh_pkg::rsp_type rsp_data
);

   import rmfh_pkg::*;

   localparam int PTR_W = $clog2(THREADS);
   localparam int CNT_W = $clog2(THREADS + 1);

   logic                    held_ff, held_in;
   logic [TID_W-1:0]        owner_ff, owner_in;
   logic [DEPTH_BITS-1:0]   depth_ff, depth_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    bypass_ff, bypass_in;
   logic [TID_W-1:0]        bypass_tid_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, rsp_in;

   logic                    accept;
   logic                    push;
   logic [TID_W-1:0]        ram_q;
   logic [TID_W-1:0]        head_tid;
   logic [DEPTH_BITS-1:0]   depth_dec;
   logic [31:0]             depth_wide;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // An entry written into an empty queue lands at the head while the RAM still
   // returns the old word, so it is forwarded for the following cycle.
   assign head_tid  = bypass_ff ? bypass_tid_ff : ram_q;
   assign depth_dec = depth_ff - DEPTH_BITS'(1);

   rmfh_ram #(
      .WIDTH (TID_W),
      .DEPTH (THREADS)
   ) u_waiters (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (req_data.thread_id),
      .rd_addr (head_in),
      .rd_data (ram_q)
   );

   always_comb begin
      held_in  = held_ff;
      owner_in = owner_ff;
      depth_in = depth_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      push     = 1'b0;
      rsp_in.status       = ST_NOT_OWNER;
      rsp_in.woken_valid  = 1'b0;
      rsp_in.woken_thread = '0;

      if (accept) begin
         if (req_data.op == OP_LOCK) begin
            if (held_ff && req_data.thread_id == owner_ff) begin
               if (depth_ff != '1) begin
                  depth_in = depth_ff + DEPTH_BITS'(1);
               end
               rsp_in.status = ST_NESTED;
            end else if (!held_ff) begin
               held_in       = 1'b1;
               owner_in      = req_data.thread_id;
               depth_in      = DEPTH_BITS'(1);
               rsp_in.status = ST_GRANTED;
            end else if (!req_data.wait_req) begin
               rsp_in.status = ST_FAILED;
            end else if (count_ff == CNT_W'(THREADS)) begin
               rsp_in.status = ST_FULL;
            end else begin
               push          = 1'b1;
               tail_in       = (tail_ff == PTR_W'(THREADS - 1)) ? '0 : tail_ff + PTR_W'(1);
               count_in      = count_ff + CNT_W'(1);
               rsp_in.status = ST_QUEUED;
            end
         end else if (held_ff && req_data.thread_id == owner_ff) begin
            if (depth_dec != '0) begin
               depth_in      = depth_dec;
               rsp_in.status = ST_HELD;
            end else if (count_ff != '0) begin
               head_in             = (head_ff == PTR_W'(THREADS - 1)) ? '0
                                                                      : head_ff + PTR_W'(1);
               count_in            = count_ff - CNT_W'(1);
               owner_in            = head_tid;
               depth_in            = DEPTH_BITS'(1);
               rsp_in.status       = ST_HELD;
               rsp_in.woken_valid  = 1'b1;
               rsp_in.woken_thread = head_tid;
            end else begin
               held_in       = 1'b0;
               owner_in      = '0;
               depth_in      = '0;
               rsp_in.status = ST_FREED;
            end
         end
      end

      depth_wide       = 32'(depth_in);
      rsp_in.depth_now = depth_wide[DEPTH_NOW_W-1:0];
      bypass_in        = push && (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         owner_ff     <= '0;
         depth_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         owner_ff     <= owner_in;
         depth_ff     <= depth_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         bypass_ff    <= bypass_in;
         rsp_valid_ff <= accept;
      end
      bypass_tid_ff <= req_data.thread_id;
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
